@@ hw/rtl/trs_transform_compose_unit_assert.svh @@
// Assertion macros shared by the transform composer RTL.
// Each macro expects clk and arst_n to exist in the using module.
`ifndef TRS_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH
`define TRS_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH

// same-cycle implication
`define TRS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/trs_pkg.sv @@
`default_nettype none

package trs_pkg;

	// one Q-format word
	typedef logic signed [31:0] q_t;

	// input beat: quat x,y,z,w at index 0..3
	typedef struct packed {
		q_t [3:0] quat;
		q_t [2:0] pos;
		q_t [2:0] scl;
	} in_item_t;

	// classified item handed from front to back: rot[column][row]
	typedef struct packed {
		q_t [2:0][2:0] rot;
		q_t [2:0]      pos;
		q_t [2:0]      scl;
	} rot_entry_t;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// column codes
	localparam logic [1:0] COL_FIRST = 2'd0;
	localparam logic [1:0] COL_LAST  = 2'd3;

	// quaternion product operands: xx yy zz xy xz yz wx wy wz
	localparam int NUM_PROD = 9;
	localparam int PROD_A [NUM_PROD] = '{0, 1, 2, 0, 0, 1, 3, 3, 3};
	localparam int PROD_B [NUM_PROD] = '{0, 1, 2, 1, 2, 2, 0, 1, 2};

	// clamp to the signed 32-bit range
	function automatic q_t sat32(input logic signed [63:0] v);
		q_t r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/trs_transform_compose_unit.sv @@
// TRS transform composer.
// Input channel (in_valid/in_ready): one beat carries a quaternion, a position
// and a per-axis scale, all signed Q(31-FRAC_BITS).FRAC_BITS.
// Output channel (out_valid/out_ready): four beats per input, the columns of
// the 4x4 matrix T*R*S in order 0, 1, 2, 3; last_column marks column 3.
// Columns 0..2 are rotation columns times their scale, row3 = 0; column 3
// carries the position with row3 = 1.0.
// Path: an input beat passes the front product stage, the queue, the back
// product stage and the output register; the columns then follow one per
// cycle while the receiver takes them, all through the single output port. The
// front takes inputs every cycle until four items sit in its product stage and
// 4-entry queue together.
// Reset clears the pipeline valids, queue pointers, credit and column
// counters; no clearing pass is needed. When out_ready is low the output beat
// holds and the back stalls; the front keeps accepting until it runs out of
// credits.
`default_nettype none

module trs_transform_compose_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  trs_pkg::q_t quat_x,
	input  trs_pkg::q_t quat_y,
	input  trs_pkg::q_t quat_z,
	input  trs_pkg::q_t quat_w,
	input  trs_pkg::q_t pos_x,
	input  trs_pkg::q_t pos_y,
	input  trs_pkg::q_t pos_z,
	input  trs_pkg::q_t scale_x,
	input  trs_pkg::q_t scale_y,
	input  trs_pkg::q_t scale_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  column_index,
	output trs_pkg::q_t row0,
	output trs_pkg::q_t row1,
	output trs_pkg::q_t row2,
	output trs_pkg::q_t row3,
	output logic        last_column
);
	import trs_pkg::*;

	in_item_t   in_item;
	rot_entry_t push_entry;
	rot_entry_t head;
	logic       push;
	logic       pop;
	logic       empty;

	// gather the input beat
	assign in_item.quat = {quat_w, quat_z, quat_y, quat_x};
	assign in_item.pos  = {pos_z, pos_y, pos_x};
	assign in_item.scl  = {scale_z, scale_y, scale_x};

	trs_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.credit_ret (pop),
		.push       (push),
		.push_entry (push_entry)
	);

	trs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	trs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_index (column_index),
		.row0         (row0),
		.row1         (row1),
		.row2         (row2),
		.row3         (row3),
		.last_column  (last_column)
	);

endmodule

`default_nettype wire

@@ hw/rtl/trs_front.sv @@
`default_nettype none

module trs_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trs_pkg::in_item_t  in_item,
	input  logic               credit_ret,
	output logic               push,
	output trs_pkg::rot_entry_t push_entry
);
	import trs_pkg::*;

	// floored product width and rotation sum width
	localparam int PW = 64 - FRAC_BITS;
	localparam int RW = 67 - FRAC_BITS;

	logic                    accept;
	logic [Q_CNT_W-1:0]      cnt_q;
	logic                    valid_s1;
	logic signed [63:0]      full [NUM_PROD];
	logic signed [PW-1:0]    prod_s1 [NUM_PROD];
	logic signed [RW-1:0]    ext [NUM_PROD];
	logic signed [RW-1:0]    rot_w [9];
	logic signed [RW-1:0]    one_e;
	q_t [2:0]                pos_s1;
	q_t [2:0]                scl_s1;

	// credits: items in s1 plus queue occupancy never exceed the queue depth
	assign in_ready = (cnt_q < Q_CNT_W'(Q_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && !credit_ret) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!accept && credit_ret) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// nine quaternion products, one multiplier each
	for (genvar k = 0; k < NUM_PROD; k++) begin : g_prod
		assign full[k] = 64'($signed(in_item.quat[PROD_A[k]]))
			* 64'($signed(in_item.quat[PROD_B[k]]));
		assign ext[k]  = RW'(prod_s1[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// floored products and pass-through fields
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				prod_s1[k] <= PW'(full[k] >>> FRAC_BITS);
			end
			pos_s1 <= in_item.pos;
			scl_s1 <= in_item.scl;
		end
	end

	// rotation elements; ext order is xx yy zz xy xz yz wx wy wz
	assign one_e = {{(RW - 1){1'b0}}, 1'b1} << FRAC_BITS;

	always_comb begin
		rot_w[0] = one_e - ((ext[1] + ext[2]) <<< 1);
		rot_w[1] = (ext[3] + ext[8]) <<< 1;
		rot_w[2] = (ext[4] - ext[7]) <<< 1;
		rot_w[3] = (ext[3] - ext[8]) <<< 1;
		rot_w[4] = one_e - ((ext[0] + ext[2]) <<< 1);
		rot_w[5] = (ext[5] + ext[6]) <<< 1;
		rot_w[6] = (ext[4] + ext[7]) <<< 1;
		rot_w[7] = (ext[5] - ext[6]) <<< 1;
		rot_w[8] = one_e - ((ext[0] + ext[1]) <<< 1);
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				push_entry.rot[c][r] = sat32(64'(rot_w[c * 3 + r]));
			end
		end
		push_entry.pos = pos_s1;
		push_entry.scl = scl_s1;
	end

	assign push = valid_s1;

endmodule

`default_nettype wire

@@ hw/rtl/trs_queue.sv @@
`default_nettype none

module trs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  trs_pkg::rot_entry_t push_entry,
	input  logic                pop,
	output logic                empty,
	output trs_pkg::rot_entry_t head
);
	import trs_pkg::*;

	rot_entry_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                full;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`include "trs_transform_compose_unit_assert.svh"

	`TRS_ASSERT_IMPL(a_no_overflow, push && !pop, !full, "queue written while full")
	`TRS_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue popped while empty")

endmodule

`default_nettype wire

@@ hw/rtl/trs_back.sv @@
`default_nettype none

module trs_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  trs_pkg::rot_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          column_index,
	output trs_pkg::q_t         row0,
	output trs_pkg::q_t         row1,
	output trs_pkg::q_t         row2,
	output trs_pkg::q_t         row3,
	output logic                last_column
);
	import trs_pkg::*;

	localparam q_t ONE_Q = 32'sd1 <<< FRAC_BITS;

	logic                out_free;
	logic                b1_ld;
	logic                issue;
	logic [1:0]          col_q;
	logic [1:0]          csel;
	logic                b1_valid_s1;
	logic [1:0]          col_s1;
	logic signed [63:0]  mul [3];
	logic signed [63:0]  prod_s1 [3];
	logic                out_valid_q;
	logic [1:0]          column_index_q;
	q_t [2:0]            row_q;
	logic                last_q;

	// handshake flow: output slot, then product stage, then queue head
	assign out_free = !out_valid_q || out_ready;
	assign b1_ld    = !b1_valid_s1 || out_free;
	assign issue    = !empty && b1_ld;
	assign pop      = issue && (col_q == COL_LAST);

	// column sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= COL_FIRST;
		end else if (issue) begin
			col_q <= col_q + 1'b1;
		end
	end

	// scale multipliers, one per row
	assign csel = (col_q == COL_LAST) ? 2'd0 : col_q;

	for (genvar r = 0; r < 3; r++) begin : g_mul
		assign mul[r] = 64'($signed(head.rot[csel][r])) * 64'($signed(head.scl[csel]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_s1 <= 1'b0;
		end else if (b1_ld) begin
			b1_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			col_s1 <= col_q;
			for (int r = 0; r < 3; r++) begin
				prod_s1[r] <= (col_q == COL_LAST) ? 64'($signed(head.pos[r])) : mul[r];
			end
		end
	end

	// output register: floor and saturate scaled rows, pass the position, fixed row 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= b1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && b1_valid_s1) begin
			column_index_q <= col_s1;
			last_q         <= (col_s1 == COL_LAST);
			for (int r = 0; r < 3; r++) begin
				row_q[r] <= (col_s1 == COL_LAST) ? prod_s1[r][31:0]
					: sat32(prod_s1[r] >>> FRAC_BITS);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = column_index_q;
	assign row0         = row_q[0];
	assign row1         = row_q[1];
	assign row2         = row_q[2];
	assign row3         = last_q ? ONE_Q : '0;
	assign last_column  = last_q;

	`include "trs_transform_compose_unit_assert.svh"

	`TRS_ASSERT_NEXT(a_col_step, issue && (col_q != COL_LAST), col_q == $past(col_q) + 2'd1, "column sequence skipped")
	`TRS_ASSERT_IMPL(a_pop_at_end, pop, issue && (col_q == COL_LAST), "entry released before its last column")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trs_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam q_t ONE         = q_t'(1 << FRAC_BITS);
	localparam q_t Q_MAX       = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN       = 32'sh8000_0000;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_TAIL  = 20;
	localparam int SHOW_LIMIT  = 10;

	// receiver pacing styles
	typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_MOSTLY} rx_mode_t;
	// how a random word is drawn
	typedef enum int {W_FULL, W_UNIT, W_CORNER} word_kind_t;

	// one matrix column as it leaves the block
	typedef struct packed {
		logic [1:0] col;
		q_t         r0;
		q_t         r1;
		q_t         r2;
		q_t         r3;
		logic       last;
	} column_t;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic in_valid = 1'b0;
	q_t   quat_x   = '0;
	q_t   quat_y   = '0;
	q_t   quat_z   = '0;
	q_t   quat_w   = '0;
	q_t   pos_x    = '0;
	q_t   pos_y    = '0;
	q_t   pos_z    = '0;
	q_t   scale_x  = '0;
	q_t   scale_y  = '0;
	q_t   scale_z  = '0;
	logic out_ready = 1'b0;

	logic       in_ready;
	logic       out_valid;
	logic [1:0] column_index;
	q_t         row0;
	q_t         row1;
	q_t         row2;
	q_t         row3;
	logic       last_column;

	column_t pending_columns[$];
	int      bad_columns  = 0;
	int      quiet_cycles = 0;
	int      hold_request = 0;

	trs_transform_compose_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.scale_x(scale_x),
		.scale_y(scale_y),
		.scale_z(scale_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.column_index(column_index),
		.row0(row0),
		.row1(row1),
		.row2(row2),
		.row3(row3),
		.last_column(last_column)
	);

	// 50 MHz clock
	initial begin
		forever #10 clk = ~clk;
	end

	// exact product floored to the fraction bits
	function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
	                                             input logic signed [63:0] b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic q_t clamp_word(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return Q_MAX;
		end
		if (v < -64'sd2147483648) begin
			return Q_MIN;
		end
		return q_t'(v[31:0]);
	endfunction

	// expected T*R*S columns for one transform beat
	function automatic void compose_columns(input in_item_t item);
		logic signed [63:0] x, y, z, w, one;
		logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [63:0] rot [3][3];
		logic signed [63:0] scl [3];
		column_t            c;
		int                 ci;
		x = item.quat[0];
		y = item.quat[1];
		z = item.quat[2];
		w = item.quat[3];
		one = 64'sd1 <<< FRAC_BITS;
		for (ci = 0; ci < 3; ci++) begin
			scl[ci] = item.scl[ci];
		end
		xx = q_mul(x, x); yy = q_mul(y, y); zz = q_mul(z, z);
		xy = q_mul(x, y); xz = q_mul(x, z); yz = q_mul(y, z);
		wx = q_mul(w, x); wy = q_mul(w, y); wz = q_mul(w, z);
		// rot[column][row], quaternion taken as is
		rot[0][0] = one - 2 * (yy + zz);
		rot[0][1] = 2 * (xy + wz);
		rot[0][2] = 2 * (xz - wy);
		rot[1][0] = 2 * (xy - wz);
		rot[1][1] = one - 2 * (xx + zz);
		rot[1][2] = 2 * (yz + wx);
		rot[2][0] = 2 * (xz + wy);
		rot[2][1] = 2 * (yz - wx);
		rot[2][2] = one - 2 * (xx + yy);
		for (ci = 0; ci < 3; ci++) begin
			c.col  = 2'(ci);
			c.r0   = clamp_word(q_mul(clamp_word(rot[ci][0]), scl[ci]));
			c.r1   = clamp_word(q_mul(clamp_word(rot[ci][1]), scl[ci]));
			c.r2   = clamp_word(q_mul(clamp_word(rot[ci][2]), scl[ci]));
			c.r3   = '0;
			c.last = 1'b0;
			pending_columns.push_back(c);
		end
		// translation column passes straight through
		c.col  = COL_LAST;
		c.r0   = item.pos[0];
		c.r1   = item.pos[1];
		c.r2   = item.pos[2];
		c.r3   = ONE;
		c.last = 1'b1;
		pending_columns.push_back(c);
	endfunction

	function automatic void note_mismatch(input string what);
		bad_columns++;
		if (bad_columns <= SHOW_LIMIT) begin
			$display("[%0t] ERROR %s", $realtime, what);
		end
	endfunction

	function automatic in_item_t make_item(input q_t x, input q_t y, input q_t z, input q_t w,
	                                       input q_t px, input q_t py, input q_t pz,
	                                       input q_t sx, input q_t sy, input q_t sz);
		in_item_t item;
		item.quat = {w, z, y, x};
		item.pos  = {pz, py, px};
		item.scl  = {sz, sy, sx};
		return item;
	endfunction

	function automatic q_t rand_word(input word_kind_t kind);
		case (kind)
			W_UNIT: begin
				return q_t'($urandom_range(0, 2 << FRAC_BITS)) - ONE;
			end
			W_CORNER: begin
				case ($urandom_range(0, 6))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return -32'sd1;
					4: return ONE;
					5: return -ONE;
					default: return 32'sd1;
				endcase
			end
			default: begin
				return q_t'($urandom);
			end
		endcase
	endfunction

	// mostly sane transforms, some full-range and mixed corner noise
	function automatic in_item_t random_transform();
		in_item_t item;
		int       shape;
		int       k;
		shape = $urandom_range(0, 9);
		for (k = 0; k < 4; k++) begin
			if (shape < 6) begin
				item.quat[k] = rand_word(W_UNIT);
			end else if (shape < 8) begin
				item.quat[k] = rand_word(W_FULL);
			end else begin
				item.quat[k] = rand_word(word_kind_t'($urandom_range(0, 2)));
			end
		end
		for (k = 0; k < 3; k++) begin
			if (shape < 6) begin
				item.pos[k] = rand_word(W_FULL);
				item.scl[k] = rand_word(W_UNIT) <<< 2;
			end else if (shape < 8) begin
				item.pos[k] = rand_word(W_FULL);
				item.scl[k] = rand_word(W_FULL);
			end else begin
				item.pos[k] = rand_word(word_kind_t'($urandom_range(0, 2)));
				item.scl[k] = rand_word(word_kind_t'($urandom_range(0, 2)));
			end
		end
		return item;
	endfunction

	// drive one beat and hold it until taken
	task automatic send_transform(input in_item_t item);
		@(negedge clk);
		quat_x   <= item.quat[0];
		quat_y   <= item.quat[1];
		quat_z   <= item.quat[2];
		quat_w   <= item.quat[3];
		pos_x    <= item.pos[0];
		pos_y    <= item.pos[1];
		pos_z    <= item.pos[2];
		scale_x  <= item.scl[0];
		scale_y  <= item.scl[1];
		scale_z  <= item.scl[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		compose_columns(item);
	endtask

	task automatic idle_input(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// random bursts, some with no gap behind them
	task automatic run_bursts(input int count);
		int sent;
		int burst;
		int k;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < count; k++) begin
				send_transform(random_transform());
				sent++;
			end
			idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
		end
	endtask

	task automatic test_directed_corners();
		// identity rotation, unit scale
		send_transform(make_item('0, '0, '0, ONE, '0, '0, '0, ONE, ONE, ONE));
		send_transform(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		send_transform(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX, Q_MAX));
		send_transform(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN));
		send_transform(make_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			-32'sd1, -32'sd1, -32'sd1, -32'sd1));
		// quarter turn about z with mixed scales
		send_transform(make_item('0, '0, 32'sd46341, 32'sd46341, 3 * ONE, -5 * ONE,
			32'sd7, 2 * ONE, ONE / 2, -ONE));
		// unnormalized quaternion
		send_transform(make_item(2 * ONE, 3 * ONE, -ONE, 4 * ONE, ONE, ONE, ONE,
			ONE, ONE, ONE));
		// rotation element beyond 32 bits, clamped before scaling
		send_transform(make_item(Q_MAX, '0, '0, '0, '0, '0, '0, ONE, ONE, ONE));
		send_transform(make_item('0, Q_MIN, '0, Q_MAX, '0, '0, '0, ONE / 4, -ONE, 3));
		// scaled element overflows both ways
		send_transform(make_item(100 * ONE, 100 * ONE, '0, '0, '0, '0, '0,
			1000 * ONE, 1000 * ONE, 1000 * ONE));
		send_transform(make_item(100 * ONE, 100 * ONE, '0, '0, '0, '0, '0,
			-1000 * ONE, -1000 * ONE, -1000 * ONE));
		// translation extremes pass through
		send_transform(make_item('0, '0, '0, '0, Q_MAX, Q_MIN, -32'sd1, '0, '0, '0));
		// tiny products flooring toward minus infinity
		send_transform(make_item(-32'sd1, 32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1,
			'0, -32'sd1, -32'sd1, -32'sd1));
		send_transform(make_item(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
		send_transform(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0,
			Q_MAX, Q_MIN, Q_MAX));
		idle_input(3);
	endtask

	task automatic test_random_traffic();
		run_bursts(420);
	endtask

	// receiver holds off while beats keep coming, input must back up
	task automatic test_output_stall();
		hold_request = HOLD_CYCLES;
		repeat (30) send_transform(random_transform());
		idle_input(2);
	endtask

	// sender stops until every column is back, then resumes
	task automatic test_drain_pause();
		run_bursts(20);
		idle_input(1);
		while (pending_columns.size() != 0) @(posedge clk);
		run_bursts(30);
	endtask

	// receiver pacing, with a long hold when asked
	initial begin : rx_pacing
		rx_mode_t mode;
		int       span;
		int       k;
		forever begin
			if (hold_request > 0) begin
				span = hold_request;
				hold_request = 0;
				repeat (span) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(8, 60);
				for (k = 0; k < span && hold_request == 0; k++) begin
					@(negedge clk);
					case (mode)
						RX_OPEN:    out_ready <= 1'b1;
						RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
						RX_CADENCE: out_ready <= (k % 3 != 0);
						default:    out_ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// column checker
	always @(posedge clk) begin
		column_t want;
		column_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{column_index, row0, row1, row2, row3, last_column};
			if (pending_columns.size() == 0) begin
				note_mismatch($sformatf("unexpected column %0d rows %h %h %h %h last %b",
					got.col, got.r0, got.r1, got.r2, got.r3, got.last));
			end else begin
				want = pending_columns.pop_front();
				if (got.col !== want.col || got.r0 !== want.r0 || got.r1 !== want.r1 ||
				    got.r2 !== want.r2 || got.r3 !== want.r3 || got.last !== want.last) begin
					note_mismatch($sformatf(
						"column exp %0d %h %h %h %h last %b, got %0d %h %h %h %h last %b",
						want.col, want.r0, want.r1, want.r2, want.r3, want.last,
						got.col, got.r0, got.r1, got.r2, got.r3, got.last));
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("trs_transform_compose_unit verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : main_seq
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_corners();
		test_random_traffic();
		test_output_stall();
		test_drain_pause();
		idle_input(1);
		while (pending_columns.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (bad_columns == 0) begin
			$display("trs_transform_compose_unit verification clean");
		end else begin
			$display("trs_transform_compose_unit verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
